// File: rtl/core/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg: shared types for the first-fit heap allocator
// Status codes, controller states, header write selectors and the command
// and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ffha_pkg;

    // Walk pointer width: holds a block start plus a full block stride
    localparam int PTR_W  = 17;
    localparam int SIZE_W = 15;
    localparam int REQ_W  = 16;
    localparam int OADR_W = 12;
    localparam int ST_W   = 3;

    typedef enum logic [ST_W-1:0] {
        ST_OK           = 3'd0,
        ST_NO_FIT       = 3'd1,
        ST_INVALID_SIZE = 3'd2,
        ST_NULL         = 3'd3,
        ST_UNINIT       = 3'd4,
        ST_OUT_OF_RANGE = 3'd5,
        ST_NOT_START    = 3'd6,
        ST_ALREADY_FREE = 3'd7
    } st_code_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_START,
        S_ACHK,
        S_ATOP,
        S_AEVAL,
        S_AREM,
        S_AOK,
        S_FTOP,
        S_FEVAL,
        S_FNEVAL,
        S_FCUR,
        S_FPREV,
        S_FOK,
        S_RD0,
        S_RD1,
        S_RD2,
        S_WR0,
        S_WR1,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        HW_INIT,
        HW_TAKE_REQ,
        HW_TAKE_ALL,
        HW_REM,
        HW_FREE,
        HW_PREV
    } hw_sel_t;

    typedef enum logic {
        RD_CUR,
        RD_NXT
    } rd_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     walk_init;
        logic     advance;
        logic     merge;
        rd_sel_t  rd_sel;
        logic     rd_byte;
        logic     cap_b0;
        logic     cap_cur;
        logic     cap_nxt;
        logic     hw_load;
        hw_sel_t  hw_sel;
        logic     wr;
        logic     wr_byte;
        logic     set_st;
        st_code_t st;
        logic     set_addr;
        logic     emit;
    } cmd_t;

    typedef struct packed {
        logic is_free_op;
        logic is_null;
        logic init;
        logic range_bad;
        logic req_big;
        logic req_zero;
        logic cur_lt_end;
        logic cur_le_last;
        logic cur_past;
        logic cur_hit;
        logic fit;
        logic split;
        logic used;
        logic nxt_in;
        logic has_prev;
        logic prev_used;
        logic out_free;
    } stat_t;

endpackage

// File: rtl/core/ffha_ram.sv
// ----------------------------------------------------------------------------
// ffha_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write, then register the read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// File: rtl/core/ffha_dp.sv
// ----------------------------------------------------------------------------
// ffha_dp: allocator datapath
// Holds the request, the walk pointers and block headers, the header store
// and the result registers; acts on commands from the controller.
// ----------------------------------------------------------------------------
module ffha_dp #(
    parameter int MEM_BYTES = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ffha_pkg::cmd_t             cmd,
    output ffha_pkg::stat_t            stat,
    input  logic                       in_op,
    input  logic [ffha_pkg::REQ_W-1:0] in_req,
    input  logic [ffha_pkg::REQ_W-1:0] in_faddr,
    input  logic                       in_null,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [ffha_pkg::OADR_W-1:0] out_addr,
    output logic [ffha_pkg::ST_W-1:0]  out_st
);

    import ffha_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);
    localparam logic [PTR_W-1:0]  MEM_P   = PTR_W'(MEM_BYTES);
    localparam logic [PTR_W-1:0]  LAST_P  = PTR_W'(MEM_BYTES - 1);
    localparam logic [PTR_W-1:0]  REQ_MAX = PTR_W'(MEM_BYTES - 4);
    localparam logic [SIZE_W-1:0] INIT_SZ = SIZE_W'(MEM_BYTES - 4);
    localparam logic [PTR_W-1:0]  TWO_P   = PTR_W'(2);

    // Request and walk state
    logic                 op_reg, null_reg, init_reg;
    logic [REQ_W-1:0]     req_reg, fa_reg;
    logic [PTR_W-1:0]     cur_reg, prev_reg;
    logic                 has_prev_reg, prev_used_reg, used_reg, nxt_used_reg;
    logic [SIZE_W-1:0]    sz_reg, prev_sz_reg, nxt_sz_reg;
    logic [7:0]           b0_reg;
    logic                 rd_ok_reg;
    logic [PTR_W-1:0]     hw_addr_reg;
    logic [SIZE_W-1:0]    hw_size_reg;
    logic                 hw_used_reg;
    logic [OADR_W-1:0]    pend_addr_reg, out_addr_reg;
    st_code_t             pend_st_reg;
    logic [ST_W-1:0]      out_st_reg;
    logic                 out_valid_reg;

    logic [PTR_W-1:0]     nxt_addr, rd_addr, wr_addr, req_ext, cur2;
    logic [7:0]           rdata, rbyte, wdata;
    logic                 we;

    assign req_ext  = PTR_W'(req_reg);
    assign cur2     = cur_reg + TWO_P;
    assign nxt_addr = cur2 + PTR_W'(sz_reg);
    assign rd_addr  = ((cmd.rd_sel == RD_NXT) ? nxt_addr : cur_reg) + PTR_W'(cmd.rd_byte);
    assign rbyte    = rd_ok_reg ? rdata : 8'd0;
    assign wr_addr  = hw_addr_reg + PTR_W'(cmd.wr_byte);
    assign wdata    = cmd.wr_byte ? hw_size_reg[7:0] : {hw_used_reg, hw_size_reg[14:8]};
    assign we       = cmd.wr && (wr_addr < MEM_P);

    ffha_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_hdr_ram (
        .clk   (clk),
        .we    (we),
        .waddr (wr_addr[AW-1:0]),
        .wdata (wdata),
        .raddr (rd_addr[AW-1:0]),
        .rdata (rdata)
    );

    // Status back to the controller
    always_comb
    begin
        stat.is_free_op  = op_reg;
        stat.is_null     = null_reg;
        stat.init        = init_reg;
        stat.range_bad   = (fa_reg < REQ_W'(2)) || (PTR_W'(fa_reg) > LAST_P);
        stat.req_big     = req_ext > REQ_MAX;
        stat.req_zero    = req_reg == '0;
        stat.cur_lt_end  = cur_reg < LAST_P;
        stat.cur_le_last = cur_reg <= LAST_P;
        stat.cur_past    = cur2 > PTR_W'(fa_reg);
        stat.cur_hit     = cur2 == PTR_W'(fa_reg);
        stat.fit         = !used_reg && (REQ_W'(sz_reg) >= req_reg);
        stat.split       = PTR_W'(sz_reg) > (req_ext + PTR_W'(3));
        stat.used        = used_reg;
        stat.nxt_in      = nxt_addr < MEM_P;
        stat.has_prev    = has_prev_reg;
        stat.prev_used   = prev_used_reg;
        stat.out_free    = !out_valid_reg || out_ready;
    end

    // Heap initialised flag and result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.hw_load && (cmd.hw_sel == HW_INIT))
            begin
                init_reg <= 1'b1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rd_ok_reg <= rd_addr < MEM_P;
        if (cmd.load_in)
        begin
            op_reg        <= in_op;
            req_reg       <= in_req;
            fa_reg        <= in_faddr;
            null_reg      <= in_null;
            pend_addr_reg <= '0;
            pend_st_reg   <= ST_OK;
        end
        if (cmd.walk_init)
        begin
            cur_reg      <= TWO_P;
            has_prev_reg <= 1'b0;
        end
        if (cmd.advance)
        begin
            prev_reg      <= cur_reg;
            prev_sz_reg   <= sz_reg;
            prev_used_reg <= used_reg;
            has_prev_reg  <= 1'b1;
            cur_reg       <= nxt_addr;
        end
        if (cmd.cap_b0)
        begin
            b0_reg <= rbyte;
        end
        if (cmd.cap_cur)
        begin
            used_reg <= b0_reg[7];
            sz_reg   <= {b0_reg[6:0], rbyte};
        end
        if (cmd.cap_nxt)
        begin
            nxt_used_reg <= b0_reg[7];
            nxt_sz_reg   <= {b0_reg[6:0], rbyte};
        end
        // Fold a free successor into the freed block
        if (cmd.merge && !nxt_used_reg)
        begin
            sz_reg <= sz_reg + nxt_sz_reg + SIZE_W'(2);
        end
        if (cmd.hw_load)
        begin
            case (cmd.hw_sel)
                HW_INIT:
                begin
                    hw_addr_reg <= TWO_P;
                    hw_size_reg <= INIT_SZ;
                    hw_used_reg <= 1'b0;
                end
                HW_TAKE_REQ:
                begin
                    hw_addr_reg <= cur_reg;
                    hw_size_reg <= req_reg[SIZE_W-1:0];
                    hw_used_reg <= 1'b1;
                end
                HW_TAKE_ALL:
                begin
                    hw_addr_reg <= cur_reg;
                    hw_size_reg <= sz_reg;
                    hw_used_reg <= 1'b1;
                end
                HW_REM:
                begin
                    hw_addr_reg <= cur2 + req_ext;
                    hw_size_reg <= sz_reg - req_reg[SIZE_W-1:0] - SIZE_W'(2);
                    hw_used_reg <= 1'b0;
                end
                HW_FREE:
                begin
                    hw_addr_reg <= cur_reg;
                    hw_size_reg <= sz_reg;
                    hw_used_reg <= 1'b0;
                end
                HW_PREV:
                begin
                    hw_addr_reg <= prev_reg;
                    hw_size_reg <= prev_sz_reg + sz_reg + SIZE_W'(2);
                    hw_used_reg <= 1'b0;
                end
                default:
                begin
                    hw_addr_reg <= cur_reg;
                    hw_size_reg <= sz_reg;
                    hw_used_reg <= used_reg;
                end
            endcase
        end
        if (cmd.set_st)
        begin
            pend_st_reg <= cmd.st;
        end
        if (cmd.set_addr)
        begin
            pend_addr_reg <= cur2[OADR_W-1:0];
        end
        if (cmd.emit)
        begin
            out_addr_reg <= pend_addr_reg;
            out_st_reg   <= pend_st_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_addr  = out_addr_reg;
    assign out_st    = out_st_reg;

endmodule

// File: rtl/core/ffha_ctrl.sv
// ----------------------------------------------------------------------------
// ffha_ctrl: allocator controller
// Sequences header reads and writes for the list walk of each request and
// hands the result beat to the output register.
// ----------------------------------------------------------------------------
module ffha_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  ffha_pkg::stat_t  stat,
    output ffha_pkg::cmd_t   cmd
);

    import ffha_pkg::*;

    state_t  state_reg, state_next;
    state_t  ret_reg, ret_next;
    rd_sel_t rdsel_reg, rdsel_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            rdsel_reg <= RD_CUR;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            rdsel_reg <= rdsel_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        rdsel_next = rdsel_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (!stat.is_free_op)
                begin
                    if (!stat.init)
                    begin
                        ret_next   = S_ACHK;
                        state_next = S_WR0;
                    end
                    else
                    begin
                        state_next = S_ACHK;
                    end
                end
                else if (stat.is_null || !stat.init || stat.range_bad)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_FTOP;
                end
            end
            S_ACHK:
            begin
                state_next = (stat.req_big || stat.req_zero) ? S_DONE : S_ATOP;
            end
            S_ATOP:
            begin
                if (stat.cur_lt_end)
                begin
                    rdsel_next = RD_CUR;
                    ret_next   = S_AEVAL;
                    state_next = S_RD0;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_AEVAL:
            begin
                if (stat.fit)
                begin
                    ret_next   = stat.split ? S_AREM : S_AOK;
                    state_next = S_WR0;
                end
                else
                begin
                    state_next = S_ATOP;
                end
            end
            S_AREM:
            begin
                ret_next   = S_AOK;
                state_next = S_WR0;
            end
            S_AOK:
            begin
                state_next = S_DONE;
            end
            S_FTOP:
            begin
                if (stat.cur_le_last && !stat.cur_past)
                begin
                    rdsel_next = RD_CUR;
                    ret_next   = S_FEVAL;
                    state_next = S_RD0;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_FEVAL:
            begin
                if (!stat.cur_hit)
                begin
                    state_next = S_FTOP;
                end
                else if (!stat.used)
                begin
                    state_next = S_DONE;
                end
                else if (stat.nxt_in)
                begin
                    rdsel_next = RD_NXT;
                    ret_next   = S_FNEVAL;
                    state_next = S_RD0;
                end
                else
                begin
                    state_next = S_FCUR;
                end
            end
            S_FNEVAL:
            begin
                state_next = S_FCUR;
            end
            S_FCUR:
            begin
                ret_next   = S_FPREV;
                state_next = S_WR0;
            end
            S_FPREV:
            begin
                if (stat.has_prev && !stat.prev_used)
                begin
                    ret_next   = S_FOK;
                    state_next = S_WR0;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_FOK:
            begin
                state_next = S_DONE;
            end
            S_RD0:
            begin
                state_next = S_RD1;
            end
            S_RD1:
            begin
                state_next = S_RD2;
            end
            S_RD2:
            begin
                state_next = ret_reg;
            end
            S_WR0:
            begin
                state_next = S_WR1;
            end
            S_WR1:
            begin
                state_next = ret_reg;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = rdsel_reg;
        cmd.hw_sel = HW_INIT;
        cmd.st     = ST_OK;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            S_START:
            begin
                if (!stat.is_free_op)
                begin
                    cmd.hw_load = !stat.init;
                    cmd.hw_sel  = HW_INIT;
                end
                else if (stat.is_null)
                begin
                    cmd.set_st = 1'b1;
                    cmd.st     = ST_NULL;
                end
                else if (!stat.init)
                begin
                    cmd.set_st = 1'b1;
                    cmd.st     = ST_UNINIT;
                end
                else if (stat.range_bad)
                begin
                    cmd.set_st = 1'b1;
                    cmd.st     = ST_OUT_OF_RANGE;
                end
                else
                begin
                    cmd.walk_init = 1'b1;
                end
            end
            S_ACHK:
            begin
                if (stat.req_big)
                begin
                    cmd.set_st = 1'b1;
                    cmd.st     = ST_NO_FIT;
                end
                else if (stat.req_zero)
                begin
                    cmd.set_st = 1'b1;
                    cmd.st     = ST_INVALID_SIZE;
                end
                else
                begin
                    cmd.walk_init = 1'b1;
                end
            end
            S_ATOP:
            begin
                cmd.set_st = !stat.cur_lt_end;
                cmd.st     = ST_NO_FIT;
            end
            S_AEVAL:
            begin
                if (stat.fit)
                begin
                    cmd.hw_load = 1'b1;
                    cmd.hw_sel  = stat.split ? HW_TAKE_REQ : HW_TAKE_ALL;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            S_AREM:
            begin
                cmd.hw_load = 1'b1;
                cmd.hw_sel  = HW_REM;
            end
            S_AOK:
            begin
                cmd.set_addr = 1'b1;
                cmd.set_st   = 1'b1;
                cmd.st       = ST_OK;
            end
            S_FTOP:
            begin
                cmd.set_st = !(stat.cur_le_last && !stat.cur_past);
                cmd.st     = ST_NOT_START;
            end
            S_FEVAL:
            begin
                if (!stat.cur_hit)
                begin
                    cmd.advance = 1'b1;
                end
                else if (!stat.used)
                begin
                    cmd.set_st = 1'b1;
                    cmd.st     = ST_ALREADY_FREE;
                end
            end
            S_FNEVAL:
            begin
                cmd.merge = 1'b1;
            end
            S_FCUR:
            begin
                cmd.hw_load = 1'b1;
                cmd.hw_sel  = HW_FREE;
            end
            S_FPREV:
            begin
                cmd.hw_load = stat.has_prev && !stat.prev_used;
                cmd.hw_sel  = HW_PREV;
                cmd.set_st  = 1'b1;
                cmd.st      = ST_OK;
            end
            S_FOK:
            begin
                cmd.set_st = 1'b1;
                cmd.st     = ST_OK;
            end
            S_RD0:
            begin
                cmd.rd_byte = 1'b0;
            end
            S_RD1:
            begin
                cmd.rd_byte = 1'b1;
                cmd.cap_b0  = 1'b1;
            end
            S_RD2:
            begin
                cmd.cap_cur = (rdsel_reg == RD_CUR);
                cmd.cap_nxt = (rdsel_reg == RD_NXT);
            end
            S_WR0:
            begin
                cmd.wr      = 1'b1;
                cmd.wr_byte = 1'b0;
            end
            S_WR1:
            begin
                cmd.wr      = 1'b1;
                cmd.wr_byte = 1'b1;
            end
            S_DONE:
            begin
                cmd.emit = stat.out_free;
            end
            default:
            begin
                cmd.load_in = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/core/first_fit_heap_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit: first-fit heap allocator over block headers
// Top level: stream ports, controller and datapath.
// ----------------------------------------------------------------------------
// One request at a time: allocate walks the block headers from offset 2 and
// takes the first free block that fits, splitting it when enough is left;
// free walks to the block, clears its mark and merges free neighbours. Every
// request gives one result beat. Each header visited is read byte by byte
// through the single read port of the header RAM (states RD0, RD1, RD2), then
// tested, and the walk steps on; each header written is sent a byte at a time
// on the write port (WR0, WR1). A free may also read the next header and
// merge with both neighbours. The first allocate also writes the initial
// header that sets up the heap. The next request is taken once the result
// beat is in the output register, which may happen while that beat still
// waits for the sink.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_unit #(
    parameter int MEM_BYTES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // request_size[15:0], free_address[31:16]
    input  logic [1:0]  s_axis_tuser,   // operation[0], free_is_null[1]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // data_address[11:0], zero fill[15:12]
    output logic [2:0]  m_axis_tuser    // status[2:0]
);

    import ffha_pkg::*;

    cmd_t              cmd;
    stat_t             stat;
    logic [OADR_W-1:0] out_addr;

    ffha_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ffha_dp #(
        .MEM_BYTES (MEM_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_op     (s_axis_tuser[0]),
        .in_req    (s_axis_tdata[15:0]),
        .in_faddr  (s_axis_tdata[31:16]),
        .in_null   (s_axis_tuser[1]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_addr  (out_addr),
        .out_st    (m_axis_tuser)
    );

    // Pad the address to a whole beat
    assign m_axis_tdata = {4'd0, out_addr};

endmodule

// File: sim/tb_first_fit_heap_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator_unit: self-checking bench for the heap allocator
// Drives allocate and free requests over the input stream, predicts each
// status and granted address from a local model of the block headers, and
// compares every result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator_unit;
    import ffha_pkg::*;

    localparam int HEAP_BYTES = 4096;
    localparam int STALL_LIMIT = 40000;
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // request_size[15:0], free_address[31:16]
    logic [1:0]  s_axis_tuser;   // operation[0], free_is_null[1]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // data_address[11:0], zero fill[15:12]
    logic [2:0]  m_axis_tuser;   // status[2:0]

    typedef struct packed {
        logic [11:0] addr;
        st_code_t    st;
    } grant_t;

    grant_t      grant_q[$];
    logic [7:0]  heap_hdr[HEAP_BYTES];
    bit          heap_ready;
    int          live_ptrs[$];
    int          mismatches;
    int          idle_cycles;
    bit          tx_noidle;
    bit          rx_noidle;
    bit          rx_hold;
    bit          timed_out;

    first_fit_heap_allocator_unit #(.MEM_BYTES(HEAP_BYTES)) dut (.*);

    // Clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Header model helpers
    function automatic int hdr_rd(int a);
        return (a < HEAP_BYTES) ? int'(heap_hdr[a]) : 0;
    endfunction

    function automatic int hdr_size(int a);
        return ((hdr_rd(a) & 8'h7f) << 8) | hdr_rd(a + 1);
    endfunction

    function automatic bit hdr_used(int a);
        return (hdr_rd(a) & 8'h80) != 0;
    endfunction

    function automatic void hdr_set(int a, int size, bit used);
        if (a < HEAP_BYTES)
            heap_hdr[a] = {used, 7'((size >> 8) & 8'h7f)};
        if (a + 1 < HEAP_BYTES)
            heap_hdr[a + 1] = 8'(size);
    endfunction

    // Predict the allocate result and update the headers
    task automatic predict_alloc(int req, output grant_t g);
        int cur;
        int sz;
        cur = 2;
        g = '{addr: '0, st: ST_NO_FIT};
        if (!heap_ready)
        begin
            hdr_set(2, HEAP_BYTES - 4, 1'b0);
            heap_ready = 1'b1;
        end
        if (req > HEAP_BYTES - 4)
            return;
        if (req == 0)
        begin
            g.st = ST_INVALID_SIZE;
            return;
        end
        while (cur < HEAP_BYTES - 1)
        begin
            sz = hdr_size(cur);
            if (!hdr_used(cur) && sz >= req)
            begin
                if (sz > req + 3)
                begin
                    hdr_set(cur, req, 1'b1);
                    hdr_set(cur + 2 + req, sz - req - 2, 1'b0);
                end
                else
                    hdr_set(cur, sz, 1'b1);
                g.addr = 12'(cur + 2);
                g.st = ST_OK;
                live_ptrs.push_back(cur + 2);
                return;
            end
            cur += 2 + sz;
        end
    endtask

    // Predict the free result and merge neighbours
    function automatic st_code_t predict_free(int a, bit is_null);
        int cur;
        int prv;
        int sz;
        int nxt;
        bit has_prv;
        cur = 2;
        prv = 0;
        has_prv = 1'b0;
        if (is_null)
            return ST_NULL;
        if (!heap_ready)
            return ST_UNINIT;
        if (a < 2 || a > HEAP_BYTES - 1)
            return ST_OUT_OF_RANGE;
        while (cur <= HEAP_BYTES - 1)
        begin
            sz = hdr_size(cur);
            if (cur + 2 > a)
                return ST_NOT_START;
            if (cur + 2 == a)
            begin
                nxt = cur + 2 + sz;
                if (!hdr_used(cur))
                    return ST_ALREADY_FREE;
                hdr_set(cur, sz, 1'b0);
                if (nxt < HEAP_BYTES && !hdr_used(nxt))
                begin
                    sz = sz + hdr_size(nxt) + 2;
                    hdr_set(cur, sz, 1'b0);
                end
                if (has_prv && !hdr_used(prv))
                    hdr_set(prv, hdr_size(prv) + sz + 2, 1'b0);
                return ST_OK;
            end
            prv = cur;
            has_prv = 1'b1;
            cur += 2 + sz;
            if (cur + 2 > a)
                return ST_NOT_START;
        end
        return ST_NOT_START;
    endfunction

    // Send one request beat and record its expected result
    task automatic send_request(logic op, int req, int adr, bit is_null);
        grant_t g;
        @(negedge clk);
        while (!tx_noidle && $urandom_range(99) < 33)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tdata  <= {16'(adr), 16'(req)};
        s_axis_tuser  <= {is_null, op};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (op == OP_ALLOC)
            predict_alloc(req, g);
        else
        begin
            g.addr = '0;
            g.st = predict_free(adr, is_null);
        end
        grant_q.push_back(g);
    endtask

    task automatic alloc_req(int req);
        send_request(OP_ALLOC, req, $urandom_range(65535), $urandom_range(1));
    endtask

    task automatic free_req(int adr, bit is_null = 1'b0);
        send_request(OP_FREE, $urandom_range(65535), adr, is_null);
    endtask

    // Free a random live pointer, dropping it from the list
    task automatic free_live();
        int k;
        int p;
        k = $urandom_range(live_ptrs.size() - 1);
        p = live_ptrs[k];
        live_ptrs.delete(k);
        free_req(p);
    endtask

    // Result sink: random stalls, long hold-off on request
    always
    begin
        @(negedge clk);
        if (rx_hold)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= rx_noidle || ($urandom_range(99) >= 33);
    end

    // Compare each result beat with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (grant_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat addr=%0d st=%0d",
                             m_axis_tdata[11:0], m_axis_tuser);
            end
            else
            begin
                grant_t g;
                g = grant_q.pop_front();
                if (m_axis_tdata !== {4'b0, g.addr} || m_axis_tuser !== g.st)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp addr=%0d st=%0d, got addr=%0d st=%0d",
                                 g.addr, g.st, m_axis_tdata, m_axis_tuser);
                end
            end
        end
    end

    // Watchdog on cycles with no accepted beat
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Frees before the heap exists, then corner cases of allocate and free
    task automatic test_directed();
        free_req(100, 1'b1);
        free_req(100);
        alloc_req(0);             // initialises even though it fails
        alloc_req(HEAP_BYTES - 3);
        alloc_req(65535);
        free_req(16'hffff, 1'b1);
        free_req(0);
        free_req(1);
        free_req(HEAP_BYTES);
        free_req(65535);
        alloc_req(1);
        alloc_req(10);
        alloc_req(5);
        free_req(7);              // frees the second block
        free_req(4);
        free_req(4);              // double free
        free_req(7 + 10);         // header offset, not a block start
        alloc_req(HEAP_BYTES);    // no fit
        alloc_req(32768);
        while (live_ptrs.size() > 0)
            free_live();
        alloc_req(HEAP_BYTES - 4);  // whole heap
        alloc_req(1);
        free_live();
        alloc_req(HEAP_BYTES - 7);  // no split
    endtask

    // Random mix, mostly well-formed alloc and free
    task automatic test_random(int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            tx_noidle = (i % 300) < 60;
            rx_noidle = (i % 300) >= 150 && (i % 300) < 210;
            r = $urandom_range(99);
            if (live_ptrs.size() > 24 || (r < 40 && live_ptrs.size() > 0))
                free_live();
            else if (r < 85)
                alloc_req(($urandom_range(3) == 0) ? $urandom_range(1, 600)
                                                   : $urandom_range(1, 64));
            else if (r < 90)
                alloc_req($urandom_range(65535));
            else if (r < 95)
                free_req($urandom_range(HEAP_BYTES - 1));
            else
                free_req($urandom_range(65535), $urandom_range(1));
        end
        tx_noidle = 1'b0;
        rx_noidle = 1'b0;
    endtask

    // Hold the sink off while requests keep coming
    task automatic test_backpressure();
        rx_hold = 1'b1;
        fork
            begin
                repeat (400) @(negedge clk);
                rx_hold = 1'b0;
            end
            for (int i = 0; i < 8; i++)
                alloc_req($urandom_range(1, 40));
        join
    endtask

    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        heap_ready = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        tx_noidle = 1'b0;
        rx_noidle = 1'b0;
        rx_hold = 1'b0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_backpressure();
        test_random(1130);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (grant_q.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0 && grant_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: files.f
rtl/core/ffha_pkg.sv
rtl/core/ffha_ram.sv
rtl/core/ffha_dp.sv
rtl/core/ffha_ctrl.sv
rtl/core/first_fit_heap_allocator_unit.sv
sim/tb_first_fit_heap_allocator_unit.sv
